FILE: sv/tgts_pkg.sv
// Package for the touch gesture tap/swipe classifier.
// Holds the item types, event and register codes and reset constants.
// No dependencies; the area unit and the core import it.
package tgts_pkg;

  // coordinate and time widths of one poll sample
  localparam int unsigned CoordW = 12;
  localparam int unsigned TimeW = 32;
  localparam int unsigned LimitW = 16;
  localparam int unsigned CountW = 3;

  // configuration port
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;

  // rectangles that have a register of their own
  localparam int unsigned RectRegs = 4;
  localparam int unsigned NumAreasDef = 4;

  // register reset values
  localparam logic [CoordW-1:0] DragThrRst = 12'd20;
  localparam logic [CoordW-1:0] SwipeStepRst = 12'd24;
  localparam logic [LimitW-1:0] TapLimitRst = 16'd700;

  typedef enum logic [1:0] {
    EVT_NONE       = 2'd0,
    EVT_SWIPE_UP   = 2'd1,
    EVT_SWIPE_DOWN = 2'd2,
    EVT_TAP        = 2'd3
  } evt_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RECT_0     = 3'd0,
    CFG_RECT_1     = 3'd1,
    CFG_RECT_2     = 3'd2,
    CFG_RECT_3     = 3'd3,
    CFG_AREA_COUNT = 3'd4,
    CFG_DRAG_THR   = 3'd5,
    CFG_SWIPE_STEP = 3'd6,
    CFG_TAP_LIMIT  = 3'd7
  } cfg_idx_e;

  // one rectangle as packed in its register
  typedef struct packed {
    logic [CoordW-1:0] h;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } area_rect_t;

  typedef struct packed {
    logic              touched;
    logic [CoordW-1:0] touch_x;
    logic [CoordW-1:0] touch_y;
    logic [TimeW-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    evt_e              event_code;
    logic [1:0]        hit_area;
    logic [CoordW-1:0] report_x;
    logic [CoordW-1:0] report_y;
  } out_item_t;

  // hit-test query and answer between the core and the area unit
  typedef struct packed {
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    logic [CountW-1:0] count;
  } hit_req_t;

  typedef struct packed {
    logic       found;
    logic [1:0] index;
  } hit_rsp_t;

endpackage

FILE: sv/tgts_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
// Depends on nothing; the payload type is given at instantiation.
interface tgts_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/tgts_areas.sv
// Tap rectangle registers and first-match hit test.
// Depends on tgts_pkg.
module tgts_areas #(
  parameter int unsigned NUM_AREAS = tgts_pkg::NumAreasDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tgts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tgts_pkg::CfgDataW-1:0] cfg_data_i,
  input  tgts_pkg::hit_req_t            req_i,
  output tgts_pkg::hit_rsp_t            rsp_o
);
  import tgts_pkg::*;

  area_rect_t              rect_q [NUM_AREAS];
  logic [NUM_AREAS-1:0]    match;
  hit_rsp_t                rsp;

  // write rectangles; those without a register stay zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AREAS; i++) begin
        rect_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_AREAS; i++) begin
        if (i < RectRegs && cfg_we_i && cfg_idx_i == CfgIdxW'(i)) begin
          rect_q[i] <= area_rect_t'(cfg_data_i);
        end
      end
    end
  end

  // test every active rectangle, inclusive bounds, no wrap on the far edge
  always_comb begin
    for (int i = 0; i < NUM_AREAS; i++) begin
      match[i] = (32'(i) < 32'(req_i.count))
          && req_i.px >= rect_q[i].x
          && {1'b0, req_i.px} <= {1'b0, rect_q[i].x} + {1'b0, rect_q[i].w}
          && req_i.py >= rect_q[i].y
          && {1'b0, req_i.py} <= {1'b0, rect_q[i].y} + {1'b0, rect_q[i].h};
    end
  end

  // first match wins
  always_comb begin
    rsp = '0;
    for (int i = NUM_AREAS - 1; i >= 0; i--) begin
      if (match[i]) begin
        rsp.found = 1'b1;
        rsp.index = 2'(i);
      end
    end
  end

  assign rsp_o = rsp;

endmodule

FILE: sv/touch_gesture_tap_swipe_core.sv
// Top level of the touch gesture classifier: tap, swipe up, swipe down.
// Depends on tgts_pkg, tgts_stream_if and tgts_areas.
//
//   channel  | dir | payload     | transaction
//   in_i     | in  | in_item_t   | one poll sample
//   out_o    | out | out_item_t  | one gesture result per sample
//   cfg_*_i  | in  | 48-bit data | one register write
//
// A sample is registered on entry, classified from the input register and its result
// registered on out_o; one sample per cycle is sustained while out_o is ready.
// The press state updates when the input register hands its sample on, so the
// throughput is set by that compare logic alone.
// A stalled out_o holds its result while one more sample waits in the input
// register. Reset is asynchronous and resets the state, configuration and valid flags.
module touch_gesture_tap_swipe_core #(
  parameter int unsigned NUM_AREAS = tgts_pkg::NumAreasDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tgts_stream_if.sink                   in_i,
  tgts_stream_if.source                 out_o,
  input  logic                          cfg_we_i,
  input  logic [tgts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tgts_pkg::CfgDataW-1:0] cfg_data_i
);
  import tgts_pkg::*;

  // configuration registers
  logic [CountW-1:0] area_count_q;
  logic [CoordW-1:0] drag_thr_q;
  logic [CoordW-1:0] swipe_step_q;
  logic [LimitW-1:0] tap_limit_q;

  // pipeline registers
  logic      s1_valid_q;
  in_item_t  s1_q;
  logic      out_valid_q;
  out_item_t out_q;

  // press state
  logic              pressed_q, pressed_d;
  logic              dragging_q, dragging_d;
  logic [CoordW-1:0] origin_x_q, origin_x_d;
  logic [CoordW-1:0] origin_y_q, origin_y_d;
  logic [CoordW-1:0] ref_y_q, ref_y_d;
  logic [TimeW-1:0]  press_time_q, press_time_d;

  logic              adv;
  logic              in_ready;
  logic [CountW-1:0] count_eff;
  logic [CoordW-1:0] mag;
  logic              drag_now;
  logic              go_up;
  logic              go_down;
  logic [TimeW-1:0]  dur;
  hit_req_t          hit_req;
  hit_rsp_t          hit_rsp;
  out_item_t         res;

  // handshake: stage 1 moves on when the output slot is free or leaving
  assign adv      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || adv;
  assign in_i.ready = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // write scalar registers; rectangles live in the area unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_count_q <= '0;
      drag_thr_q   <= DragThrRst;
      swipe_step_q <= SwipeStepRst;
      tap_limit_q  <= TapLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_AREA_COUNT: area_count_q <= cfg_data_i[CountW-1:0];
        CFG_DRAG_THR:   drag_thr_q   <= cfg_data_i[CoordW-1:0];
        CFG_SWIPE_STEP: swipe_step_q <= cfg_data_i[CoordW-1:0];
        CFG_TAP_LIMIT:  tap_limit_q  <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // clamp the area count to the rectangles built
  assign count_eff = (32'(area_count_q) > NUM_AREAS) ? CountW'(NUM_AREAS) : area_count_q;

  assign hit_req.px    = origin_x_q;
  assign hit_req.py    = origin_y_q;
  assign hit_req.count = count_eff;

  tgts_areas #(
    .NUM_AREAS (NUM_AREAS)
  ) u_areas (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (hit_req),
    .rsp_o      (hit_rsp)
  );

  // distance from the start point, steps from the reference, press duration
  assign mag = (s1_q.touch_y >= origin_y_q) ? s1_q.touch_y - origin_y_q
                                            : origin_y_q - s1_q.touch_y;
  assign drag_now = dragging_q || (mag > drag_thr_q);
  assign go_up    = (ref_y_q > s1_q.touch_y) && ((ref_y_q - s1_q.touch_y) > swipe_step_q);
  assign go_down  = (s1_q.touch_y > ref_y_q) && ((s1_q.touch_y - ref_y_q) > swipe_step_q);
  assign dur      = s1_q.now_ms - press_time_q;

  // classify the sample in stage 1
  always_comb begin
    pressed_d    = pressed_q;
    dragging_d   = dragging_q;
    origin_x_d   = origin_x_q;
    origin_y_d   = origin_y_q;
    ref_y_d      = ref_y_q;
    press_time_d = press_time_q;
    res          = '0;
    res.event_code = EVT_NONE;
    if (s1_q.touched) begin
      res.report_x = s1_q.touch_x;
      res.report_y = s1_q.touch_y;
      if (!pressed_q) begin
        pressed_d    = 1'b1;
        dragging_d   = 1'b0;
        origin_x_d   = s1_q.touch_x;
        origin_y_d   = s1_q.touch_y;
        ref_y_d      = s1_q.touch_y;
        press_time_d = s1_q.now_ms;
      end else begin
        dragging_d = drag_now;
        if (drag_now && go_up) begin
          ref_y_d        = s1_q.touch_y;
          res.event_code = EVT_SWIPE_UP;
        end else if (drag_now && go_down) begin
          ref_y_d        = s1_q.touch_y;
          res.event_code = EVT_SWIPE_DOWN;
        end
      end
    end else if (pressed_q) begin
      pressed_d  = 1'b0;
      dragging_d = 1'b0;
      if (!dragging_q && dur < TimeW'(tap_limit_q) && hit_rsp.found) begin
        res.event_code = EVT_TAP;
        res.hit_area   = hit_rsp.index;
        res.report_x   = origin_x_q;
        res.report_y   = origin_y_q;
      end
    end
  end

  // advance the press state with each sample handed on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q    <= 1'b0;
      dragging_q   <= 1'b0;
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      ref_y_q      <= '0;
      press_time_q <= '0;
    end else if (adv) begin
      pressed_q    <= pressed_d;
      dragging_q   <= dragging_d;
      origin_x_q   <= origin_x_d;
      origin_y_q   <= origin_y_d;
      ref_y_q      <= ref_y_d;
      press_time_q <= press_time_d;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      s1_q <= in_i.data;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  // a drag only exists inside a press
  assert property (@(posedge clk_i) disable iff (!rst_ni) dragging_q |-> pressed_q)
    else $error("drag flag set without a press");

  // a press ends only on a released sample handed on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      $fell(pressed_q) |-> $past(adv && !s1_q.touched))
    else $error("press ended without a release sample");

  // input stalls only behind an occupied input register
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_ready |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // a swipe leaves the press dragging
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      adv && (res.event_code == EVT_SWIPE_UP || res.event_code == EVT_SWIPE_DOWN)
      |=> dragging_q && pressed_q)
    else $error("swipe without drag state");

  // a tap result carries the start point that was held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      adv && res.event_code == EVT_TAP |=> !pressed_q && !dragging_q
      && out_q.report_x == $past(origin_x_q) && out_q.report_y == $past(origin_y_q))
    else $error("tap result inconsistent with press state");

endmodule
